// ----- rtl/mu8_pkg.sv -----
// shared types and constants of the utf-8 to modified utf-8 converter
package mu8_pkg;

  localparam int unsigned MU8_QUEUE_DEPTH = 2;
  localparam int unsigned MU8_CP_W        = 21;

  // one decoded unit of work for the encoder side
  typedef struct packed {
    logic                err;
    logic [MU8_CP_W-1:0] cp;
  } job_t;

endpackage

// ----- rtl/mu8_in_if.sv -----
// input channel: one utf-8 byte per word
interface mu8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- rtl/mu8_out_if.sv -----
// output channel: one modified utf-8 byte per word
interface mu8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       malformed;
  logic       run_last;

  modport source (output valid, output out_byte, output malformed, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input malformed, input run_last,
                  output ready);
endinterface

// ----- rtl/utf8_to_modified_utf8_converter_unit.sv -----
// top level of the utf-8 to modified utf-8 converter
// A decoder takes one utf-8 byte per cycle whenever the job queue has room and pushes
// a job per finished code point or per error; an encoder drains the queue and sends one
// output word per cycle while out_o.ready holds, so a code point gives as many words as
// its modified utf-8 form has bytes (1, 2, 3 or 6, and 1 for an error); the output port
// sets the sustained rate. The first word for a byte is registered in the job queue and
// then in the output register. Bytes that only extend an open sequence produce no word.
module utf8_to_modified_utf8_converter_unit #(
  parameter int unsigned QueueDepth = mu8_pkg::MU8_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mu8_in_if.sink      in_i,
  mu8_out_if.source   out_o
);
  import mu8_pkg::*;

  logic full, push, empty, pop;
  job_t job, head;

  mu8_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  mu8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  mu8_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- rtl/mu8_front.sv -----
// front end: utf-8 decoder that turns bytes into code point or error jobs
module mu8_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mu8_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output mu8_pkg::job_t  job_o
);
  import mu8_pkg::*;

  localparam logic [MU8_CP_W-1:0] MinTwo   = MU8_CP_W'(32'h80);
  localparam logic [MU8_CP_W-1:0] MinThree = MU8_CP_W'(32'h800);
  localparam logic [MU8_CP_W-1:0] MinFour  = MU8_CP_W'(32'h10000);
  localparam logic [MU8_CP_W-1:0] SurLo    = MU8_CP_W'(32'hD800);
  localparam logic [MU8_CP_W-1:0] SurHi    = MU8_CP_W'(32'hDFFF);
  localparam logic [MU8_CP_W-1:0] CpMax    = MU8_CP_W'(32'h10FFFF);

  logic [MU8_CP_W-1:0] pcp_q, pcp_d, pcp_n, min_cp;
  logic [1:0]          bse_q, bse_d, slen_q, slen_d;
  logic                acc, err, b_ascii;
  logic [7:0]          b;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign b          = in_i.in_byte;
  assign b_ascii    = !b[7];
  assign pcp_n      = {pcp_q[MU8_CP_W-7:0], b[5:0]};

  always_comb begin
    case (slen_q)
      2'd1:    min_cp = MinTwo;
      2'd2:    min_cp = MinThree;
      default: min_cp = MinFour;
    endcase
  end

  always_comb begin
    pcp_d     = pcp_q;
    bse_d     = bse_q;
    slen_d    = slen_q;
    err       = 1'b0;
    push_o    = 1'b0;
    job_o.err = 1'b0;
    job_o.cp  = MU8_CP_W'(b);
    if (acc) begin
      if (bse_q == 2'd0) begin
        if (b_ascii) begin
          push_o = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          pcp_d  = MU8_CP_W'(b[4:0]);
          bse_d  = 2'd1;
          slen_d = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          pcp_d  = MU8_CP_W'(b[3:0]);
          bse_d  = 2'd2;
          slen_d = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          pcp_d  = MU8_CP_W'(b[2:0]);
          bse_d  = 2'd3;
          slen_d = 2'd3;
        end else begin
          err = 1'b1;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          pcp_d = pcp_n;
          bse_d = bse_q - 2'd1;
          if (bse_d == 2'd0) begin
            if (pcp_n < min_cp || (pcp_n >= SurLo && pcp_n <= SurHi) || pcp_n > CpMax) begin
              err = 1'b1;
            end else begin
              push_o   = 1'b1;
              job_o.cp = pcp_n;
            end
          end
        end
      end
      if (in_i.end_of_text && bse_d != 2'd0) begin
        err = 1'b1;
      end
      if (err) begin
        push_o    = 1'b1;
        job_o.err = 1'b1;
        job_o.cp  = '0;
      end
      if (err || in_i.end_of_text || (bse_d == 2'd0)) begin
        pcp_d  = '0;
        bse_d  = 2'd0;
        slen_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q  <= '0;
      bse_q  <= 2'd0;
      slen_q <= 2'd0;
    end else begin
      pcp_q  <= pcp_d;
      bse_q  <= bse_d;
      slen_q <= slen_d;
    end
  end

endmodule

// ----- rtl/mu8_fifo.sv -----
// short job queue between decoder and encoder
module mu8_fifo #(
  parameter int unsigned Depth = mu8_pkg::MU8_QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mu8_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mu8_pkg::job_t  head_o
);
  import mu8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = entries_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/mu8_back.sv -----
// back end: serializes each job into modified utf-8 output words
module mu8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  mu8_pkg::job_t  head_i,
  output logic           pop_o,
  mu8_out_if.source      out_o
);
  import mu8_pkg::*;

  logic [2:0]          idx_q, idx_d, len;
  logic                valid_q, load, last_b;
  logic [7:0]          byte_q, byte_d;
  logic                mal_q, last_q;
  logic [MU8_CP_W-1:0] v;
  logic [15:0]         u;
  logic [1:0]          k;

  function automatic logic [7:0] three(input logic [15:0] w, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = {4'hE, w[15:12]};
      2'd1:    r = {2'b10, w[11:6]};
      default: r = {2'b10, w[5:0]};
    endcase
    return r;
  endfunction

  // encoded length of the head job
  always_comb begin
    if (head_i.err) begin
      len = 3'd1;
    end else if (head_i.cp == '0) begin
      len = 3'd2;
    end else if (head_i.cp < MU8_CP_W'(32'h80)) begin
      len = 3'd1;
    end else if (head_i.cp < MU8_CP_W'(32'h800)) begin
      len = 3'd2;
    end else if (head_i.cp < MU8_CP_W'(32'h10000)) begin
      len = 3'd3;
    end else begin
      len = 3'd6;
    end
  end

  assign v = head_i.cp - MU8_CP_W'(32'h10000);

  // byte at the current position
  always_comb begin
    u = head_i.cp[15:0];
    k = idx_q[1:0];
    if (head_i.cp >= MU8_CP_W'(32'h10000)) begin
      if (idx_q < 3'd3) begin
        u = {6'b110110, v[19:10]};
      end else begin
        u = {6'b110111, v[9:0]};
        k = 2'(idx_q - 3'd3);
      end
    end
    if (head_i.err) begin
      byte_d = 8'h00;
    end else if (head_i.cp == '0) begin
      byte_d = (idx_q == 3'd0) ? 8'hC0 : 8'h80;
    end else if (head_i.cp < MU8_CP_W'(32'h80)) begin
      byte_d = head_i.cp[7:0];
    end else if (head_i.cp < MU8_CP_W'(32'h800)) begin
      byte_d = (idx_q == 3'd0) ? {3'b110, head_i.cp[10:6]} : {2'b10, head_i.cp[5:0]};
    end else begin
      byte_d = three(u, k);
    end
  end

  assign load   = !valid_q || out_o.ready;
  assign last_b = idx_q == (len - 3'd1);
  assign pop_o  = load && !empty_i && last_b;

  always_comb begin
    idx_d = idx_q;
    if (load && !empty_i) begin
      idx_d = last_b ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      byte_q <= byte_d;
      mal_q  <= head_i.err;
      last_q <= last_b;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.malformed = mal_q;
  assign out_o.run_last  = last_q;

  a_err_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && mal_q |-> last_q && byte_q == 8'h00)
    else $error("error word not a lone zero word");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd5)
    else $error("byte index out of range");

  a_idx_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> !empty_i)
    else $error("job left the queue before all bytes were sent");

  a_pop_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && last_q)
    else $error("job retired without a closing word");

endmodule

// ----- sim/mu8_stream_check.sv -----
// checker of the utf-8 to modified utf-8 converter: predicts each output word and compares
`timescale 1ns / 100ps

module mu8_stream_check (
  input  logic clk_i,
  input  logic rst_ni,
  mu8_in_if    in_mon,
  mu8_out_if   out_mon,
  output int   mismatches_o,
  output int   words_due_o
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       malformed;
    logic       run_last;
  } mu8_word_t;

  mu8_word_t   due_words[$];
  logic [20:0] acc_cp;
  logic [1:0]  cont_left;
  logic [1:0]  seq_len;

  task automatic report(string msg);
    mismatches_o++;
    if (mismatches_o <= 30) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic void clear_decoder();
    acc_cp    = '0;
    cont_left = '0;
    seq_len   = '0;
  endfunction

  function automatic void queue_word(logic [7:0] ob, logic mal, logic rl);
    mu8_word_t w;
    w.out_byte  = ob;
    w.malformed = mal;
    w.run_last  = rl;
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    logic [7:0]  bs [6];
    logic [20:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    int          n;
    v  = cp - 21'h10000;
    hi = 16'hD800 + {6'd0, v[19:10]};
    lo = 16'hDC00 + {6'd0, v[9:0]};
    if (cp == 21'd0) begin
      bs[0] = 8'hC0;
      bs[1] = 8'h80;
      n = 2;
    end else if (cp < 21'h80) begin
      bs[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      bs[0] = {3'b110, cp[10:6]};
      bs[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      bs[0] = {4'hE, cp[15:12]};
      bs[1] = {2'b10, cp[11:6]};
      bs[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      // surrogate pair, each half as a three-byte form
      bs[0] = {4'hE, hi[15:12]};
      bs[1] = {2'b10, hi[11:6]};
      bs[2] = {2'b10, hi[5:0]};
      bs[3] = {4'hE, lo[15:12]};
      bs[4] = {2'b10, lo[11:6]};
      bs[5] = {2'b10, lo[5:0]};
      n = 6;
    end
    for (int i = 0; i < n; i++) begin
      queue_word(bs[i], 1'b0, i == n - 1);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eot);
    logic [20:0] min_cp;
    logic        bad;
    bad = 1'b0;
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        emit_code_point({13'd0, b});
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        acc_cp    = {16'd0, b[4:0]};
        cont_left = 2'd1;
        seq_len   = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        acc_cp    = {17'd0, b[3:0]};
        cont_left = 2'd2;
        seq_len   = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        acc_cp    = {18'd0, b[2:0]};
        cont_left = 2'd3;
        seq_len   = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      acc_cp    = {acc_cp[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        min_cp = (seq_len == 2'd1) ? 21'h80 : (seq_len == 2'd2) ? 21'h800 : 21'h10000;
        if (acc_cp < min_cp || (acc_cp >= 21'hD800 && acc_cp <= 21'hDFFF) ||
            acc_cp > 21'h10FFFF) begin
          bad = 1'b1;
        end else begin
          emit_code_point(acc_cp);
          clear_decoder();
        end
      end
    end
    // truncation: text ends inside an open sequence
    if (!bad && eot && cont_left != 2'd0) begin
      bad = 1'b1;
    end
    if (bad) begin
      queue_word(8'h00, 1'b1, 1'b1);
      clear_decoder();
    end else if (eot) begin
      clear_decoder();
    end
  endfunction

  initial begin
    mismatches_o = 0;
    words_due_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mu8_word_t w;
    if (!rst_ni) begin
      clear_decoder();
      due_words.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_words.size() == 0) begin
          report($sformatf("unexpected word %h malformed %b run_last %b",
                           out_mon.out_byte, out_mon.malformed, out_mon.run_last));
        end else begin
          w = due_words.pop_front();
          if (out_mon.out_byte !== w.out_byte) begin
            report($sformatf("out_byte %h, want %h", out_mon.out_byte, w.out_byte));
          end
          if (out_mon.malformed !== w.malformed) begin
            report($sformatf("malformed %b, want %b", out_mon.malformed, w.malformed));
          end
          if (out_mon.run_last !== w.run_last) begin
            report($sformatf("run_last %b, want %b", out_mon.run_last, w.run_last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte, in_mon.end_of_text);
      end
    end
    words_due_o = due_words.size();
  end

endmodule

// ----- sim/tb.sv -----
// testbench top of the utf-8 to modified utf-8 converter: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb;

  localparam int CyclesMax   = 200000;
  localparam int ItemsTarget = 410;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   words_sent;
  int   mismatches;
  int   words_due;
  int   phase_end;

  mu8_in_if  in_ch ();
  mu8_out_if out_ch ();

  utf8_to_modified_utf8_converter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mu8_stream_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (CyclesMax) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  task automatic send_word(logic [7:0] b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.end_of_text = eot;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // utf-8 form of cp in len bytes, of which only the first keep are sent
  task automatic send_form(logic [20:0] cp, int len, int keep, logic eot);
    logic [7:0] bs [4];
    case (len)
      1: begin
        bs[0] = cp[7:0];
      end
      2: begin
        bs[0] = {3'b110, cp[10:6]};
        bs[1] = {2'b10, cp[5:0]};
      end
      3: begin
        bs[0] = {4'hE, cp[15:12]};
        bs[1] = {2'b10, cp[11:6]};
        bs[2] = {2'b10, cp[5:0]};
      end
      default: begin
        bs[0] = {5'b11110, cp[20:18]};
        bs[1] = {2'b10, cp[17:12]};
        bs[2] = {2'b10, cp[11:6]};
        bs[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) begin
      send_word(bs[i], eot && (i == keep - 1));
    end
  endtask

  task automatic send_char();
    int          kind;
    int          len;
    int          keep;
    logic [20:0] cp;
    logic [7:0]  b;
    logic        eot;
    kind = $urandom_range(99);
    eot  = ($urandom_range(99) < 4);
    if (kind < 70) begin
      // well-formed character
      len = $urandom_range(4, 1);
      case (len)
        1:       cp = 21'($urandom_range(32'h7F));
        2:       cp = 21'($urandom_range(32'h7FF, 32'h80));
        3:       cp = 21'($urandom_range(32'hFFFF, 32'h800));
        default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
      endcase
      send_form(cp, len, len, eot);
    end else if (kind < 80) begin
      // complete but invalid: overlong, surrogate, above the code space
      case ($urandom_range(4))
        0: begin len = 2; cp = 21'($urandom_range(32'h7F)); end
        1: begin len = 3; cp = 21'($urandom_range(32'h7FF)); end
        2: begin len = 4; cp = 21'($urandom_range(32'hFFFF)); end
        3: begin len = 3; cp = 21'($urandom_range(32'hDFFF, 32'hD800)); end
        default: begin len = 4; cp = 21'($urandom_range(32'h1FFFFF, 32'h110000)); end
      endcase
      send_form(cp, len, len, eot);
    end else if (kind < 90) begin
      // sequence cut short by end of text or by a non-continuation byte
      len  = $urandom_range(4, 2);
      keep = $urandom_range(len - 1, 1);
      cp   = 21'($urandom_range(32'h1FFFFF));
      if ($urandom_range(1) == 1) begin
        send_form(cp, len, keep, 1'b1);
      end else begin
        send_form(cp, len, keep, 1'b0);
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) begin
          b[6] = 1'b1;
        end
        send_word(b, eot);
      end
    end else begin
      send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.end_of_text = 1'b0;
    rst_ni            = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    words_sent        = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero, bad lead, lone continuation
    send_word(8'h00, 1'b0);
    send_word(8'hC0, 1'b0);
    send_word(8'h80, 1'b0);
    // largest two-byte form, ending the text
    send_word(8'hDF, 1'b0);
    send_word(8'hBF, 1'b1);
    // overlong three-byte form
    send_word(8'hE0, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    // surrogate
    send_word(8'hED, 1'b0);
    send_word(8'hA0, 1'b0);
    send_word(8'h80, 1'b0);
    // smallest and largest supplementary code points
    send_word(8'hF0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF4, 1'b0);
    send_word(8'h8F, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    // above the code space, then an invalid lead byte
    send_word(8'hF4, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    // bad continuation, then truncation at end of text
    send_word(8'hC2, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hE1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      phase_end = words_sent + ItemsTarget / 4;
      while (words_sent < phase_end) send_char();
    end
    in_ch.valid = 1'b0;

    while (words_due != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- utf8_to_modified_utf8_converter_unit.f -----
rtl/mu8_pkg.sv
rtl/mu8_in_if.sv
rtl/mu8_out_if.sv
rtl/mu8_front.sv
rtl/mu8_fifo.sv
rtl/mu8_back.sv
rtl/utf8_to_modified_utf8_converter_unit.sv
sim/mu8_stream_check.sv
sim/tb.sv
